@@ src/plk_pkg.sv @@
// Shared constants, types and command/status bundles for the piecewise linear lookup.
package plk_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int X_W        = 16;
	localparam int Y_W        = 16;
	localparam int PIDX_W     = 6;
	localparam int DVD_W      = 32;
	localparam int DVD_CNT_W  = $clog2(DVD_W);
	localparam int TDATA_W    = 40;

	localparam logic CFG_POINT_COUNT = 1'b0;
	localparam logic CFG_TABLE_VALID = 1'b1;

	localparam logic MODE_WRITE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_LAST,
		ST_CHK_LAST,
		ST_CHK_FIRST,
		ST_SCAN,
		ST_SEG,
		ST_DIV_START,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ADDR_LAST,
		ADDR_ZERO,
		ADDR_NEXT
	} addr_sel_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_RD_Y,
		RES_Y0,
		RES_Y1,
		RES_DIV
	} res_sel_t;

	typedef struct packed {
		logic      wr_mem;
		logic      load_x;
		logic      rd_en;
		addr_sel_t addr_sel;
		logic      prev_load;
		logic      seg_load;
		logic      mul_load;
		logic      div_start;
		logic      res_load;
		res_sel_t  res_sel;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic table_valid;
		logic x_gt_rd;
		logic x_lt_rd;
		logic in_seg;
		logic at_last;
		logic le_x0;
		logic ge_x1;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

@@ src/plk_ctrl.sv @@
// Sequencer for table writes, segment search, interpolation and result hand-off.
module plk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          mode,
	output logic          s_tready,
	input  plk_pkg::sts_t sts,
	output plk_pkg::cmd_t cmd
);
	import plk_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.addr_sel  = ADDR_LAST;
		cmd.res_sel   = RES_ZERO;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (mode == MODE_WRITE) begin
						cmd.wr_mem = 1'b1;
					end else begin
						cmd.load_x = 1'b1;
						if (sts.table_valid) begin
							state_d = ST_RD_LAST;
						end else begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_ZERO;
							state_d      = ST_DONE;
						end
					end
				end
			end
			ST_RD_LAST: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = ADDR_LAST;
				state_d      = ST_CHK_LAST;
			end
			ST_CHK_LAST: begin
				if (sts.x_gt_rd) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_RD_Y;
					state_d      = ST_DONE;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = ADDR_ZERO;
					state_d      = ST_CHK_FIRST;
				end
			end
			ST_CHK_FIRST: begin
				if (sts.x_lt_rd) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_RD_Y;
					state_d      = ST_DONE;
				end else begin
					cmd.prev_load = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.addr_sel  = ADDR_NEXT;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.in_seg) begin
					cmd.seg_load = 1'b1;
					state_d      = ST_SEG;
				end else if (sts.at_last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ZERO;
					state_d      = ST_DONE;
				end else begin
					cmd.prev_load = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.addr_sel  = ADDR_NEXT;
				end
			end
			ST_SEG: begin
				if (sts.le_x0) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_Y0;
					state_d      = ST_DONE;
				end else if (sts.ge_x1) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_Y1;
					state_d      = ST_DONE;
				end else begin
					cmd.mul_load = 1'b1;
					state_d      = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_DIV;
					state_d      = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/plk_div.sv @@
// Restoring divider, one quotient bit per cycle.
module plk_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [plk_pkg::DVD_W-1:0] dividend,
	input  logic [plk_pkg::X_W-1:0]   divisor,
	output logic                      done,
	output logic [plk_pkg::DVD_W-1:0] quotient
);
	import plk_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DVD_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [X_W-1:0]       den_q;
	logic [X_W-1:0]       rem_q;
	logic [X_W:0]         rem_sh;
	logic [X_W:0]         rem_sub;
	logic                 q_bit;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[DVD_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		q_bit   = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DVD_CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[X_W-1:0] : rem_sh[X_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

@@ src/plk_dp.sv @@
// Datapath: configuration, breakpoint memory, compares, multiply, divide and output register.
module plk_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [plk_pkg::CNT_W-1:0]   cfg_data,
	input  logic [plk_pkg::TDATA_W-1:0] s_tdata,
	input  plk_pkg::cmd_t               cmd,
	output plk_pkg::sts_t               sts,
	input  logic                        m_tready,
	output logic                        m_tvalid,
	output logic [plk_pkg::Y_W-1:0]     m_tdata
);
	import plk_pkg::*;

	logic [CNT_W-1:0]  pc_q;
	logic              tv_q;
	logic [IDX_W-1:0]  last_idx;

	logic [X_W-1:0]    x_mem [MAX_POINTS];
	logic [Y_W-1:0]    y_mem [MAX_POINTS];

	logic [PIDX_W-1:0] wr_idx;
	logic [X_W-1:0]    wr_x;
	logic [Y_W-1:0]    wr_y;

	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  idx_q;
	logic [X_W-1:0]    rd_x_q;
	logic [Y_W-1:0]    rd_y_q;
	logic [X_W-1:0]    x_q;
	logic [X_W-1:0]    prev_x_q;
	logic [Y_W-1:0]    prev_y_q;
	logic [X_W-1:0]    x0_q;
	logic [Y_W-1:0]    y0_q;
	logic [X_W-1:0]    x1_q;
	logic [Y_W-1:0]    y1_q;

	logic [X_W-1:0]    dx;
	logic signed [Y_W:0]   dy;
	logic signed [2*Y_W+1:0] prod_q;
	logic [X_W-1:0]    den_q;
	logic              neg;
	logic [2*Y_W+1:0]  mag;
	logic              div_done;
	logic [DVD_W-1:0]  quo;
	logic [Y_W+1:0]    q18;
	logic [Y_W+1:0]    qs18;
	logic [Y_W+1:0]    sum18;

	logic [Y_W-1:0]    res_d;
	logic [Y_W-1:0]    res_q;
	logic              m_tvalid_q;
	logic [Y_W-1:0]    m_tdata_q;

	assign wr_idx = s_tdata[PIDX_W-1:0];
	assign wr_x   = s_tdata[PIDX_W +: X_W];
	assign wr_y   = s_tdata[PIDX_W+X_W +: Y_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= CNT_W'(2);
			tv_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POINT_COUNT: pc_q <= cfg_data;
				CFG_TABLE_VALID: tv_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (pc_q < CNT_W'(2)) begin
			last_idx = IDX_W'(1);
		end else if (pc_q > CNT_W'(MAX_POINTS)) begin
			last_idx = IDX_W'(MAX_POINTS - 1);
		end else begin
			last_idx = IDX_W'(pc_q - CNT_W'(1));
		end
	end

	always_comb begin
		case (cmd.addr_sel)
			ADDR_LAST: rd_addr = last_idx;
			ADDR_ZERO: rd_addr = '0;
			ADDR_NEXT: rd_addr = idx_q + 1'b1;
			default:   rd_addr = last_idx;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_mem) begin
			x_mem[IDX_W'(wr_idx)] <= wr_x;
			y_mem[IDX_W'(wr_idx)] <= wr_y;
		end
		if (cmd.rd_en) begin
			rd_x_q <= x_mem[rd_addr];
			rd_y_q <= y_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			idx_q <= rd_addr;
		end
		if (cmd.load_x) begin
			x_q <= wr_x;
		end
		if (cmd.prev_load) begin
			prev_x_q <= rd_x_q;
			prev_y_q <= rd_y_q;
		end
		if (cmd.seg_load) begin
			x0_q <= prev_x_q;
			y0_q <= prev_y_q;
			x1_q <= rd_x_q;
			y1_q <= rd_y_q;
		end
		if (cmd.mul_load) begin
			prod_q <= (2*Y_W+2)'($signed({1'b0, dx}) * dy);
			den_q  <= x1_q - x0_q;
		end
		if (cmd.res_load) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		dx  = x_q - x0_q;
		dy  = $signed({y1_q[Y_W-1], y1_q}) - $signed({y0_q[Y_W-1], y0_q});
		neg = prod_q[2*Y_W+1];
		mag = neg ? (-prod_q) : prod_q;
	end

	plk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag[DVD_W-1:0]),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		q18   = {1'b0, quo[Y_W:0]};
		qs18  = neg ? (-q18) : q18;
		sum18 = {{2{y0_q[Y_W-1]}}, y0_q} + qs18;
		case (cmd.res_sel)
			RES_ZERO: res_d = '0;
			RES_RD_Y: res_d = rd_y_q;
			RES_Y0:   res_d = y0_q;
			RES_Y1:   res_d = y1_q;
			RES_DIV:  res_d = sum18[Y_W-1:0];
			default:  res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= res_q;
		end
	end

	always_comb begin
		sts.table_valid = tv_q;
		sts.x_gt_rd     = (x_q > rd_x_q);
		sts.x_lt_rd     = (x_q < rd_x_q);
		sts.in_seg      = (x_q >= prev_x_q) && (x_q <= rd_x_q);
		sts.at_last     = (idx_q == last_idx);
		sts.le_x0       = (x_q <= x0_q);
		sts.ge_x1       = (x_q >= x1_q);
		sts.div_done    = div_done;
		sts.out_busy    = m_tvalid_q & ~m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ src/piecewise_linear_lookup.sv @@
// Piecewise linear interpolation table: top level.
// Write beat: no result; the next beat may follow at once.
// Lookup beat: with the table invalid the result is zero and no search is made; else it waits on
// the linear breakpoint scan (one memory read per cycle, up to 63 segments) and, for a point
// inside a segment, the shift-subtract divider; s_tready returns as the result's m_tvalid rises.
// Reset clears configuration (point count 2, table invalid) and control; memory is not cleared.
module piecewise_linear_lookup (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [plk_pkg::CNT_W-1:0]   cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [plk_pkg::TDATA_W-1:0] s_tdata,  // point_index, x_value, y_value, zero pad
	input  logic                        s_tuser,  // mode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [plk_pkg::Y_W-1:0]     m_tdata   // y_result
);
	import plk_pkg::*;

	cmd_t cmd;
	sts_t sts;

	plk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	plk_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule

@@ src/plk_chk.sv @@
// Port-level checks for the piecewise linear lookup, bound to the top level.
module plk_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [plk_pkg::Y_W-1:0]     m_tdata
);
	import plk_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed while stalled");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_WRITE) |=> !$rose(m_tvalid))
		else $error("write beat produced a result");

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != MODE_WRITE) |=> !s_tready)
		else $error("input taken while a lookup is in progress");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a lookup in progress");

endmodule

bind piecewise_linear_lookup plk_chk u_plk_chk (.*);

@@ bench/piecewise_linear_lookup_tb.sv @@
// Self-checking bench for the piecewise linear lookup: directed cases, then random tables.
`timescale 1ns / 100ps

module piecewise_linear_lookup_tb;

	import plk_pkg::*;

	localparam logic MODE_LOOKUP    = ~MODE_WRITE;
	localparam int   RANDOM_ITEMS   = 500;
	localparam int   SETTLE_CYCLES  = 120;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   REPORT_LIMIT   = 10;

	typedef enum int {
		SINK_OPEN,
		SINK_CHOPPY,
		SINK_SLOW
	} sink_style_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [CNT_W-1:0]   cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [Y_W-1:0]     m_tdata;

	// breakpoint table and registers as the block should hold them
	logic [X_W-1:0]        tbl_x [MAX_POINTS];
	logic signed [Y_W-1:0] tbl_y [MAX_POINTS];
	logic [CNT_W-1:0]      reg_count = 7'd2;
	logic                  reg_valid = 1'b0;

	logic signed [Y_W-1:0] pending_y [$];
	logic signed [Y_W-1:0] want_y;

	int          errors      = 0;
	int          n_writes    = 0;
	int          n_lookups   = 0;
	int          n_checked   = 0;
	int          n_cfg       = 0;
	int          n_tables    = 0;
	int          burst_left  = 0;
	int          quiet_cycles = 0;
	int          sink_left   = 0;
	sink_style_t sink_style  = SINK_OPEN;

	piecewise_linear_lookup uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned points_in_use(input logic [CNT_W-1:0] count);
		if (count < 2)
			return 2;
		if (count > MAX_POINTS)
			return MAX_POINTS;
		return count;
	endfunction

	function automatic logic signed [Y_W-1:0] interpolate(input logic [X_W-1:0] x);
		int unsigned n;
		longint xa, xb, ya, yb, xq;
		n  = points_in_use(reg_count);
		xq = x;
		if (!reg_valid)
			return '0;
		if (x > tbl_x[n-1])
			return tbl_y[n-1];
		if (x < tbl_x[0])
			return tbl_y[0];
		for (int i = 0; i + 1 < n; i++) begin
			xa = tbl_x[i];
			xb = tbl_x[i+1];
			ya = tbl_y[i];
			yb = tbl_y[i+1];
			if (xq >= xa && xq <= xb) begin
				if (xq <= xa)
					return 16'(ya);
				if (xq >= xb)
					return 16'(yb);
				return 16'(ya + (xq - xa) * (yb - ya) / (xb - xa));
			end
		end
		return '0;
	endfunction

	task automatic send_item(input logic mode, input logic [PIDX_W-1:0] idx,
	                         input logic [X_W-1:0] x, input logic signed [Y_W-1:0] y);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {2'b00, y, x, idx};
		do @(posedge clk); while (s_tready !== 1'b1);
		if (mode == MODE_WRITE) begin
			tbl_x[idx] = x;
			tbl_y[idx] = y;
			n_writes++;
		end else begin
			pending_y.push_back(interpolate(x));
			n_lookups++;
		end
	endtask

	task automatic write_point(input int unsigned idx, input logic [X_W-1:0] x,
	                           input logic signed [Y_W-1:0] y);
		send_item(MODE_WRITE, PIDX_W'(idx), x, y);
	endtask

	task automatic query(input logic [X_W-1:0] x);
		send_item(MODE_LOOKUP, PIDX_W'($urandom), x, Y_W'($urandom));
	endtask

	// drop valid, wait for every result, then let a trailing write settle
	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_y.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CNT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == CFG_POINT_COUNT)
			reg_count = value;
		else
			reg_valid = value[0];
		n_cfg++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_table(input int unsigned count, input bit ordered);
		int unsigned step_max, cur;
		logic [X_W-1:0] xs;
		step_max = ($urandom_range(0, 3) == 0) ? 3 : 65535 / count;
		cur = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, step_max);
		for (int i = 0; i < count; i++) begin
			if (!ordered)
				xs = X_W'($urandom);
			else if (i == count - 1 && $urandom_range(0, 3) == 0)
				xs = 16'hFFFF;
			else
				xs = X_W'(cur);
			write_point(i, xs, Y_W'($urandom));
			if ($urandom_range(0, 7) != 0)
				cur += $urandom_range(0, step_max);
		end
		n_tables++;
	endtask

	function automatic logic [X_W-1:0] pick_x(input int unsigned count);
		int unsigned k;
		k = $urandom_range(0, count - 1);
		case ($urandom_range(0, 5))
			0: return X_W'($urandom);
			1: return tbl_x[k];
			2: return tbl_x[k] - 16'd1;
			3: return tbl_x[k] + 16'd1;
			4: return X_W'((32'(tbl_x[k]) + 32'(tbl_x[(k + 1 < count) ? k + 1 : k])) / 2);
			default: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
		endcase
	endfunction

	task automatic test_invalid_table;
		write_point(0, 16'd0, 16'sh8000);
		write_point(1, 16'hFFFF, 16'sh7FFF);
		query(16'd0);
		query(16'hFFFF);
	endtask

	task automatic test_full_range_segment;
		drain();
		write_reg(CFG_TABLE_VALID, 7'd1);
		query(16'd0);
		query(16'd1);
		query(16'd32768);
		query(16'hFFFE);
		query(16'hFFFF);
	endtask

	task automatic test_segment_cases;
		write_point(0, 16'd1000, 16'sd100);
		write_point(1, 16'd2000, -16'sd100);
		write_point(2, 16'd2000, 16'sd7);
		write_point(3, 16'd3000, 16'sd7);
		drain();
		write_reg(CFG_POINT_COUNT, 7'd4);
		query(16'd999);
		query(16'd1000);
		query(16'd1500);
		query(16'd1999);
		query(16'd2000);
		query(16'd2500);
		query(16'd3000);
		query(16'd3001);
	endtask

	task automatic test_unordered_points;
		write_point(1, 16'd500, 16'sd9);
		drain();
		write_reg(CFG_POINT_COUNT, 7'd3);
		query(16'd1500);
		query(16'd700);
	endtask

	task automatic test_random_tables;
		int unsigned used, base;
		logic [CNT_W-1:0] count_val;
		bit first;
		first = 1'b1;
		base  = n_writes + n_lookups;
		while (n_writes + n_lookups - base < RANDOM_ITEMS) begin
			drain();
			case ($urandom_range(0, 9))
				0: count_val = CNT_W'($urandom_range(0, 1));
				1: count_val = CNT_W'(MAX_POINTS);
				2: count_val = CNT_W'($urandom_range(65, 127));
				3: count_val = CNT_W'($urandom_range(9, 64));
				default: count_val = CNT_W'($urandom_range(2, 8));
			endcase
			// the whole table must be written before any lookup can reach it
			if (first)
				count_val = 7'd127;
			used = points_in_use(count_val);
			write_reg(CFG_POINT_COUNT, count_val);
			write_reg(CFG_TABLE_VALID, CNT_W'($urandom_range(0, 7) != 0));
			if (first || $urandom_range(0, 3) != 0)
				load_table(used, $urandom_range(0, 5) != 0);
			first = 1'b0;
			repeat ($urandom_range(6, 30)) begin
				if ($urandom_range(0, 11) == 0)
					write_point($urandom_range(0, MAX_POINTS - 1), X_W'($urandom),
					            Y_W'($urandom));
				else
					query(pick_x(used));
			end
		end
	endtask

	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_left  = $urandom_range(20, 120);
			sink_style = sink_style_t'($urandom_range(0, 2));
		end
		sink_left--;
		case (sink_style)
			SINK_OPEN:   m_tready <= 1'b1;
			SINK_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
			default:     m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_y.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("result %0d arrived with no lookup outstanding", $signed(m_tdata));
			end else begin
				want_y = pending_y.pop_front();
				n_checked++;
				if (m_tdata !== want_y) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("y_result mismatch on result %0d: expected %0d, got %0d",
						         n_checked, want_y, $signed(m_tdata));
				end
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("no beat for %0d cycles, %0d results outstanding", WATCHDOG_LIMIT,
		         pending_y.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_POINT_COUNT;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tuser   = MODE_LOOKUP;
		s_tdata   = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_invalid_table();
		test_full_range_segment();
		test_segment_cases();
		test_unordered_points();
		test_random_tables();
		drain();

		errors += pending_y.size();
		$display("covered %0d breakpoint writes, %0d lookups (%0d checked), %0d register writes",
		         n_writes, n_lookups, n_checked, n_cfg);
		$display("%0d random tables, clamped point counts, unordered and zero-width segments",
		         n_tables);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
src/plk_pkg.sv
src/plk_ctrl.sv
src/plk_div.sv
src/plk_dp.sv
src/piecewise_linear_lookup.sv
src/plk_chk.sv
bench/piecewise_linear_lookup_tb.sv
